// ===== rtl/core/bpmrp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmrp_pkg: shared types and constants for the matrix record parser
// Holds the parse phase codes, the parser state bundle and the sign extender.
// ----------------------------------------------------------------------------
package bpmrp_pkg;

  localparam int ValW   = 31;
  localparam int WidW   = 5;
  localparam int PhaseW = 4;
  localparam int NumVal = 6;

  // parse phase codes
  localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
  localparam logic [PhaseW-1:0] PH_SFLAG = 4'd1;
  localparam logic [PhaseW-1:0] PH_SWID  = 4'd2;
  localparam logic [PhaseW-1:0] PH_SX    = 4'd3;
  localparam logic [PhaseW-1:0] PH_SY    = 4'd4;
  localparam logic [PhaseW-1:0] PH_RFLAG = 4'd5;
  localparam logic [PhaseW-1:0] PH_RWID  = 4'd6;
  localparam logic [PhaseW-1:0] PH_R0    = 4'd7;
  localparam logic [PhaseW-1:0] PH_R1    = 4'd8;
  localparam logic [PhaseW-1:0] PH_TWID  = 4'd9;
  localparam logic [PhaseW-1:0] PH_TX    = 4'd10;
  localparam logic [PhaseW-1:0] PH_TY    = 4'd11;

  // value slots
  localparam int IDX_SCALE_X = 0;
  localparam int IDX_SCALE_Y = 1;
  localparam int IDX_SKEW_0  = 2;
  localparam int IDX_SKEW_1  = 3;
  localparam int IDX_TRANS_X = 4;
  localparam int IDX_TRANS_Y = 5;

  localparam logic [WidW-1:0] WIDTH_FIELD_BITS = 5'd5;
  localparam logic [ValW-1:0] SCALE_DEFAULT    = 31'd65536;

  typedef logic [NumVal-1:0][ValW-1:0] vals_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [WidW-1:0]   rem;
    logic [WidW-1:0]   width;
    logic [ValW-1:0]   acc;
    vals_t             vals;
    logic              done;
  } pstate_t;

  // sign extend the low w bits of v to the full value width
  function automatic logic [ValW-1:0] sext(input logic [ValW-1:0] v,
                                           input logic [WidW-1:0] w);
    logic [ValW-1:0] r;
    logic [WidW-1:0] top;
    top = w - 5'd1;
    r = '0;
    if (w != '0) begin
      for (int i = 0; i < ValW; i++) begin
        r[i] = (i < int'(w)) ? v[i] : v[top];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bpmrp_bit_step.sv =====
// ----------------------------------------------------------------------------
// bpmrp_bit_step: one bit of the record parser
// Advances the parser state by a single stream bit; eight are chained per byte.
// ----------------------------------------------------------------------------
module bpmrp_bit_step (
  input  bpmrp_pkg::pstate_t cur,
  input  logic               bit_in,
  output bpmrp_pkg::pstate_t nxt
);

  logic [bpmrp_pkg::ValW-1:0] acc_sh;
  logic [bpmrp_pkg::WidW-1:0] rem_dec;
  logic [bpmrp_pkg::WidW-1:0] wid_new;
  logic [bpmrp_pkg::ValW-1:0] val_new;

  assign acc_sh  = {cur.acc[bpmrp_pkg::ValW-2:0], bit_in};
  assign rem_dec = cur.rem - 5'd1;
  assign wid_new = acc_sh[bpmrp_pkg::WidW-1:0];
  assign val_new = bpmrp_pkg::sext(acc_sh, cur.width);

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      bpmrp_pkg::PH_SFLAG, bpmrp_pkg::PH_RFLAG: begin
        if (bit_in) begin
          nxt.rem   = bpmrp_pkg::WIDTH_FIELD_BITS;
          nxt.acc   = '0;
          nxt.phase = cur.phase + 4'd1;
        end else if (cur.phase == bpmrp_pkg::PH_SFLAG) begin
          nxt.vals[bpmrp_pkg::IDX_SCALE_X] = bpmrp_pkg::SCALE_DEFAULT;
          nxt.vals[bpmrp_pkg::IDX_SCALE_Y] = bpmrp_pkg::SCALE_DEFAULT;
          nxt.phase = bpmrp_pkg::PH_RFLAG;
        end else begin
          nxt.vals[bpmrp_pkg::IDX_SKEW_0] = '0;
          nxt.vals[bpmrp_pkg::IDX_SKEW_1] = '0;
          nxt.rem   = bpmrp_pkg::WIDTH_FIELD_BITS;
          nxt.acc   = '0;
          nxt.phase = bpmrp_pkg::PH_TWID;
        end
      end
      bpmrp_pkg::PH_SWID, bpmrp_pkg::PH_RWID, bpmrp_pkg::PH_TWID: begin
        nxt.acc = acc_sh;
        nxt.rem = rem_dec;
        if (rem_dec == '0) begin
          nxt.width = wid_new;
          nxt.acc   = '0;
          if (wid_new == '0) begin
            unique case (cur.phase)
              bpmrp_pkg::PH_SWID: begin
                nxt.vals[bpmrp_pkg::IDX_SCALE_X] = '0;
                nxt.vals[bpmrp_pkg::IDX_SCALE_Y] = '0;
                nxt.phase = bpmrp_pkg::PH_RFLAG;
              end
              bpmrp_pkg::PH_RWID: begin
                nxt.vals[bpmrp_pkg::IDX_SKEW_0] = '0;
                nxt.vals[bpmrp_pkg::IDX_SKEW_1] = '0;
                nxt.rem   = bpmrp_pkg::WIDTH_FIELD_BITS;
                nxt.phase = bpmrp_pkg::PH_TWID;
              end
              default: begin
                // empty translate pair closes the record
                nxt.vals[bpmrp_pkg::IDX_TRANS_X] = '0;
                nxt.vals[bpmrp_pkg::IDX_TRANS_Y] = '0;
                nxt.phase = bpmrp_pkg::PH_IDLE;
                nxt.rem   = '0;
                nxt.done  = 1'b1;
              end
            endcase
          end else begin
            nxt.rem   = wid_new;
            nxt.phase = cur.phase + 4'd1;
          end
        end
      end
      bpmrp_pkg::PH_SX, bpmrp_pkg::PH_SY, bpmrp_pkg::PH_R0,
      bpmrp_pkg::PH_R1, bpmrp_pkg::PH_TX, bpmrp_pkg::PH_TY: begin
        nxt.acc = acc_sh;
        nxt.rem = rem_dec;
        if (rem_dec == '0) begin
          nxt.acc = '0;
          unique case (cur.phase)
            bpmrp_pkg::PH_SX: begin
              nxt.vals[bpmrp_pkg::IDX_SCALE_X] = val_new;
              nxt.rem   = cur.width;
              nxt.phase = bpmrp_pkg::PH_SY;
            end
            bpmrp_pkg::PH_SY: begin
              nxt.vals[bpmrp_pkg::IDX_SCALE_Y] = val_new;
              nxt.phase = bpmrp_pkg::PH_RFLAG;
            end
            bpmrp_pkg::PH_R0: begin
              nxt.vals[bpmrp_pkg::IDX_SKEW_0] = val_new;
              nxt.rem   = cur.width;
              nxt.phase = bpmrp_pkg::PH_R1;
            end
            bpmrp_pkg::PH_R1: begin
              nxt.vals[bpmrp_pkg::IDX_SKEW_1] = val_new;
              nxt.rem   = bpmrp_pkg::WIDTH_FIELD_BITS;
              nxt.phase = bpmrp_pkg::PH_TWID;
            end
            bpmrp_pkg::PH_TX: begin
              nxt.vals[bpmrp_pkg::IDX_TRANS_X] = val_new;
              nxt.rem   = cur.width;
              nxt.phase = bpmrp_pkg::PH_TY;
            end
            default: begin
              nxt.vals[bpmrp_pkg::IDX_TRANS_Y] = val_new;
              nxt.phase = bpmrp_pkg::PH_IDLE;
              nxt.rem   = '0;
              nxt.done  = 1'b1;
            end
          endcase
        end
      end
      default: begin
        // idle and unused codes take no bits
      end
    endcase
  end

endmodule

// ===== rtl/core/bpmrp_out_buf.sv =====
// ----------------------------------------------------------------------------
// bpmrp_out_buf: result register with skid stage
// Two-entry output buffer so the input side keeps moving while a result waits.
// ----------------------------------------------------------------------------
module bpmrp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bpmrp_pkg::vals_t push_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bpmrp_pkg::vals_t out_data
);

  logic             skid_valid;
  bpmrp_pkg::vals_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= push;
        if (push) begin
          skid_data <= push_data;
        end
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= push_data;
        end
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/bit_packed_matrix_record_parser_core.sv =====
// ----------------------------------------------------------------------------
// bit_packed_matrix_record_parser_core: bit-packed 2d matrix record parser
// Parses one byte per beat, msb first, and emits scale, skew and translate.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | tdata[7:0] data_byte, tuser[0] record_start
//  m_axis  | out | tdata: scale_x, scale_y, skew_first, skew_second,
//          |     |        translate_x, translate_y (31 bits each, lsb first)
//
//  one input beat per cycle while s_axis_tready is high: all eight bits of
//  a byte go through a chain of eight bit-step cells between the parser
//  state registers and the result buffer.
//  rst is synchronous: the parser returns to idle and the result buffer
//  empties.
//  the result buffer holds two results; s_axis_tready is low while both
//  entries are full and comes back the cycle after the receiver takes one.
//
module bit_packed_matrix_record_parser_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] record_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata    // scale_x [30:0], scale_y [61:31],
                                       // skew_first [92:62], skew_second [123:93],
                                       // translate_x [154:124], translate_y [185:155]
);

  // parser state registers
  logic [bpmrp_pkg::PhaseW-1:0] phase;
  logic [bpmrp_pkg::WidW-1:0]   rem;
  logic [bpmrp_pkg::WidW-1:0]   width;
  logic [bpmrp_pkg::ValW-1:0]   acc;
  bpmrp_pkg::vals_t             vals;

  logic                         s_accept;
  bpmrp_pkg::pstate_t           chain [0:8];
  bpmrp_pkg::vals_t             res_data;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  // start of the chain: a start flag restarts at the first bit of this byte
  always_comb begin
    chain[0].vals = vals;
    chain[0].done = 1'b0;
    if (s_axis_tuser[0]) begin
      chain[0].phase = bpmrp_pkg::PH_SFLAG;
      chain[0].rem   = '0;
      chain[0].width = '0;
      chain[0].acc   = '0;
    end else begin
      chain[0].phase = phase;
      chain[0].rem   = rem;
      chain[0].width = width;
      chain[0].acc   = acc;
    end
  end

  // msb first; once the record closes the remaining cells sit idle
  for (genvar g = 0; g < 8; g++) begin : g_step
    bpmrp_bit_step u_step (
      .cur    (chain[g]),
      .bit_in (s_axis_tdata[7-g]),
      .nxt    (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bpmrp_pkg::PH_IDLE;
      rem   <= '0;
      width <= '0;
      acc   <= '0;
      vals  <= '0;
    end else if (s_accept) begin
      phase <= chain[8].phase;
      rem   <= chain[8].rem;
      width <= chain[8].width;
      acc   <= chain[8].acc;
      vals  <= chain[8].vals;
    end
  end

  bpmrp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (s_accept && chain[8].done),
    .push_data (chain[8].vals),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_data)
  );

  assign m_axis_tdata = {6'b0, res_data};

  // ready low means the buffer is holding results
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // a new result only follows an accepted beat
  a_result_from_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(s_accept))
    else $error("result appeared without an input beat");

  // reset returns the parser to idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (phase == bpmrp_pkg::PH_IDLE))
    else $error("parser not idle after reset");

  // the parser never reaches an unused phase code
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= bpmrp_pkg::PH_TY)
    else $error("parser phase out of range");

endmodule

// ===== tb/tb_bit_packed_matrix_record_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_bit_packed_matrix_record_parser_core: matrix record parser testbench
// Streams bit-packed matrix records one byte per beat, predicts each matrix
// with a bit-serial parser of its own and checks every output beat field by
// field. Covers ignored idle bytes, restarts, truncated records, widest
// fields, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_bit_packed_matrix_record_parser_core;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_OFF     = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]   s_axis_tuser = 1'b0;    // [0] record_start
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;           // six 31-bit values, scale_x lowest

  bit_packed_matrix_record_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  typedef struct {
    bit               scale_on;
    bit               skew_on;
    logic [4:0]       w_scale;
    logic [4:0]       w_skew;
    logic [4:0]       w_trans;
    bpmrp_pkg::vals_t vals;
  } matrix_rec_t;

  string field_name [bpmrp_pkg::NumVal] = '{"scale_x", "scale_y", "skew_first",
                                            "skew_second", "translate_x", "translate_y"};

  bpmrp_pkg::vals_t expected_matrices[$];
  bit               record_bits[$];

  int bytes_sent       = 0;
  int matrices_checked = 0;
  int mismatch_count   = 0;
  int stall_cycles     = 0;
  int src_idle_pct     = 18;
  int sink_idle_pct    = 79;
  int sink_hold_left   = 0;

  // parser state of the predictor
  logic [bpmrp_pkg::PhaseW-1:0] prs_phase = bpmrp_pkg::PH_IDLE;
  logic [bpmrp_pkg::WidW-1:0]   prs_left  = '0;
  logic [bpmrp_pkg::WidW-1:0]   prs_width = '0;
  logic [bpmrp_pkg::ValW-1:0]   prs_acc   = '0;
  bpmrp_pkg::vals_t             prs_vals  = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic [bpmrp_pkg::ValW-1:0] widen_signed(
      input logic [bpmrp_pkg::ValW-1:0] raw, input logic [bpmrp_pkg::WidW-1:0] w);
    logic signed [31:0] t;
    if (w == '0) return '0;
    t = {1'b0, raw} << (32 - int'(w));
    t = t >>> (32 - int'(w));
    return t[bpmrp_pkg::ValW-1:0];
  endfunction

  // a width field has just been read: start its value pair or skip it
  function automatic bit open_pair(input int slot,
                                   input logic [bpmrp_pkg::PhaseW-1:0] value_ph,
                                   input logic [bpmrp_pkg::PhaseW-1:0] next_ph);
    prs_width = prs_acc[bpmrp_pkg::WidW-1:0];
    prs_acc   = '0;
    if (prs_width != '0) begin
      prs_left  = prs_width;
      prs_phase = value_ph;
      return 1'b0;
    end
    prs_vals[slot]     = '0;
    prs_vals[slot + 1] = '0;
    prs_left           = bpmrp_pkg::WIDTH_FIELD_BITS;
    prs_phase          = next_ph;
    return next_ph == bpmrp_pkg::PH_IDLE;
  endfunction

  // returns 1 when this bit closes the record
  function automatic bit shift_in_bit(input logic b);
    logic [bpmrp_pkg::ValW-1:0] v;
    if (prs_phase == bpmrp_pkg::PH_SFLAG || prs_phase == bpmrp_pkg::PH_RFLAG) begin
      if (b) begin
        prs_left  = bpmrp_pkg::WIDTH_FIELD_BITS;
        prs_acc   = '0;
        prs_phase = (prs_phase == bpmrp_pkg::PH_SFLAG) ? bpmrp_pkg::PH_SWID
                                                       : bpmrp_pkg::PH_RWID;
      end else if (prs_phase == bpmrp_pkg::PH_SFLAG) begin
        prs_vals[bpmrp_pkg::IDX_SCALE_X] = bpmrp_pkg::SCALE_DEFAULT;
        prs_vals[bpmrp_pkg::IDX_SCALE_Y] = bpmrp_pkg::SCALE_DEFAULT;
        prs_phase                        = bpmrp_pkg::PH_RFLAG;
      end else begin
        prs_vals[bpmrp_pkg::IDX_SKEW_0] = '0;
        prs_vals[bpmrp_pkg::IDX_SKEW_1] = '0;
        prs_left                        = bpmrp_pkg::WIDTH_FIELD_BITS;
        prs_acc                         = '0;
        prs_phase                       = bpmrp_pkg::PH_TWID;
      end
      return 1'b0;
    end
    if (prs_phase == bpmrp_pkg::PH_IDLE) return 1'b0;
    prs_acc  = {prs_acc[bpmrp_pkg::ValW-2:0], b};
    prs_left = prs_left - 5'd1;
    if (prs_left != '0) return 1'b0;
    case (prs_phase)
      bpmrp_pkg::PH_SWID:
        return open_pair(bpmrp_pkg::IDX_SCALE_X, bpmrp_pkg::PH_SX, bpmrp_pkg::PH_RFLAG);
      bpmrp_pkg::PH_RWID:
        return open_pair(bpmrp_pkg::IDX_SKEW_0, bpmrp_pkg::PH_R0, bpmrp_pkg::PH_TWID);
      bpmrp_pkg::PH_TWID:
        return open_pair(bpmrp_pkg::IDX_TRANS_X, bpmrp_pkg::PH_TX, bpmrp_pkg::PH_IDLE);
      default: ;
    endcase
    v        = widen_signed(prs_acc, prs_width);
    prs_acc  = '0;
    prs_left = prs_width;
    case (prs_phase)
      bpmrp_pkg::PH_SX: begin
        prs_vals[bpmrp_pkg::IDX_SCALE_X] = v;
        prs_phase                        = bpmrp_pkg::PH_SY;
      end
      bpmrp_pkg::PH_SY: begin
        prs_vals[bpmrp_pkg::IDX_SCALE_Y] = v;
        prs_phase                        = bpmrp_pkg::PH_RFLAG;
      end
      bpmrp_pkg::PH_R0: begin
        prs_vals[bpmrp_pkg::IDX_SKEW_0] = v;
        prs_phase                       = bpmrp_pkg::PH_R1;
      end
      bpmrp_pkg::PH_R1: begin
        prs_vals[bpmrp_pkg::IDX_SKEW_1] = v;
        prs_phase                       = bpmrp_pkg::PH_TWID;
        prs_left                        = bpmrp_pkg::WIDTH_FIELD_BITS;
      end
      bpmrp_pkg::PH_TX: begin
        prs_vals[bpmrp_pkg::IDX_TRANS_X] = v;
        prs_phase                        = bpmrp_pkg::PH_TY;
      end
      default: begin
        prs_vals[bpmrp_pkg::IDX_TRANS_Y] = v;
        prs_phase                        = bpmrp_pkg::PH_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // one byte, msb first; leftover bits after the record's end are dropped
  function automatic bit parse_byte(input logic [7:0] d, input logic st);
    int i;
    if (st) begin
      prs_phase = bpmrp_pkg::PH_SFLAG;
      prs_left  = '0;
      prs_width = '0;
      prs_acc   = '0;
    end
    if (prs_phase == bpmrp_pkg::PH_IDLE) return 1'b0;
    for (i = 7; i >= 0; i--) begin
      if (shift_in_bit(d[i])) begin
        prs_phase = bpmrp_pkg::PH_IDLE;
        prs_left  = '0;
        prs_acc   = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // record building
  // ---------------------------------------------------------------------------
  function automatic void append_field(input logic [bpmrp_pkg::ValW-1:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) record_bits.insert(record_bits.size(), v[i]);
  endfunction

  function automatic logic [bpmrp_pkg::WidW-1:0] pick_width();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(6)) : 5'($urandom_range(31));
  endfunction

  // random value of w bits, leaning on the extremes
  function automatic logic [bpmrp_pkg::ValW-1:0] pick_value(input int w);
    logic [31:0] mask;
    mask = (w == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - w));
    case ($urandom_range(7))
      0:       return mask[bpmrp_pkg::ValW-1:0] & ~(mask[bpmrp_pkg::ValW-1:0] >> 1);
      1:       return mask[bpmrp_pkg::ValW-1:0] >> 1;
      2:       return mask[bpmrp_pkg::ValW-1:0];
      default: return 31'($urandom() & mask);
    endcase
  endfunction

  function automatic matrix_rec_t random_record(input bit widest);
    matrix_rec_t r;
    r.scale_on = widest ? 1'b1 : 1'($urandom_range(1));
    r.skew_on  = widest ? 1'b1 : 1'($urandom_range(1));
    r.w_scale  = widest ? 5'd31 : pick_width();
    r.w_skew   = widest ? 5'd31 : pick_width();
    r.w_trans  = widest ? 5'd31 : pick_width();
    r.vals[bpmrp_pkg::IDX_SCALE_X] = pick_value(r.w_scale);
    r.vals[bpmrp_pkg::IDX_SCALE_Y] = pick_value(r.w_scale);
    r.vals[bpmrp_pkg::IDX_SKEW_0]  = pick_value(r.w_skew);
    r.vals[bpmrp_pkg::IDX_SKEW_1]  = pick_value(r.w_skew);
    r.vals[bpmrp_pkg::IDX_TRANS_X] = pick_value(r.w_trans);
    r.vals[bpmrp_pkg::IDX_TRANS_Y] = pick_value(r.w_trans);
    return r;
  endfunction

  // every pair carries the values a and b
  function automatic matrix_rec_t fixed_record(input bit hs, input int ws, input bit hr,
                                               input int wr, input int wt,
                                               input logic [bpmrp_pkg::ValW-1:0] a,
                                               input logic [bpmrp_pkg::ValW-1:0] b);
    matrix_rec_t r;
    r.scale_on = hs;
    r.skew_on  = hr;
    r.w_scale  = 5'(ws);
    r.w_skew   = 5'(wr);
    r.w_trans  = 5'(wt);
    r.vals     = {b, a, b, a, b, a};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic st);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (parse_byte(d, st)) expected_matrices.insert(expected_matrices.size(), prs_vals);
  endtask

  // keep > 0 cuts the record after that many bytes
  task automatic send_record(input matrix_rec_t r, input int keep);
    logic [7:0] d;
    int nbytes, i, j;
    record_bits.delete();
    append_field(31'(r.scale_on), 1);
    if (r.scale_on) begin
      append_field(31'(r.w_scale), bpmrp_pkg::WidW);
      append_field(r.vals[bpmrp_pkg::IDX_SCALE_X], r.w_scale);
      append_field(r.vals[bpmrp_pkg::IDX_SCALE_Y], r.w_scale);
    end
    append_field(31'(r.skew_on), 1);
    if (r.skew_on) begin
      append_field(31'(r.w_skew), bpmrp_pkg::WidW);
      append_field(r.vals[bpmrp_pkg::IDX_SKEW_0], r.w_skew);
      append_field(r.vals[bpmrp_pkg::IDX_SKEW_1], r.w_skew);
    end
    append_field(31'(r.w_trans), bpmrp_pkg::WidW);
    append_field(r.vals[bpmrp_pkg::IDX_TRANS_X], r.w_trans);
    append_field(r.vals[bpmrp_pkg::IDX_TRANS_Y], r.w_trans);
    // random filler after the record's end must be dropped
    while (record_bits.size() % 8 != 0)
      record_bits.insert(record_bits.size(), 1'($urandom_range(1)));
    nbytes = record_bits.size() / 8;
    if (keep > 0 && keep < nbytes) nbytes = keep;
    for (i = 0; i < nbytes; i++) begin
      for (j = 0; j < 8; j++) d[7-j] = record_bits[8*i + j];
      send_byte(d, i == 0);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : check_matrix
    bpmrp_pkg::vals_t got;
    bpmrp_pkg::vals_t want;
    int k;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[bpmrp_pkg::NumVal*bpmrp_pkg::ValW-1:0];
      if (expected_matrices.size() == 0) begin
        report_mismatch($sformatf("matrix beat with none expected, scale_x %0d",
                                  $signed(got[bpmrp_pkg::IDX_SCALE_X])));
      end else begin
        want = expected_matrices.pop_front();
        matrices_checked++;
        for (k = 0; k < bpmrp_pkg::NumVal; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("matrix %0d %s: got %0d, want %0d", matrices_checked,
                                      field_name[k], $signed(got[k]), $signed(want[k])));
          end
        end
      end
      if (m_axis_tdata[191:bpmrp_pkg::NumVal*bpmrp_pkg::ValW] !== '0)
        report_mismatch("pad bits of m_axis_tdata set");
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat in %0d cycles, %0d matrices outstanding", QUIET_LIMIT,
             expected_matrices.size());
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // bytes without a start flag while the parser is idle
  task automatic test_idle_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_directed_records();
    send_record(fixed_record(0, 0, 0, 0, 0, '0, '0), 0);           // identity, one byte
    send_record(fixed_record(1, 0, 1, 0, 0, '0, '0), 0);           // flags set, zero widths
    send_record(fixed_record(1, 1, 1, 1, 1, 31'h1, 31'h0), 0);     // one-bit values
    send_record(fixed_record(0, 0, 0, 0, 31, 31'h4000_0000, 31'h3FFF_FFFF), 0);
    send_byte(8'hA5, 1'b0);                                        // after completion
  endtask

  task automatic test_restart_mid_record();
    send_byte(8'hFF, 1'b1);              // scale at width 31, left open
    send_byte(8'h00, 1'b0);              // spans into the next byte
    send_record(fixed_record(1, 9, 0, 0, 4, 31'h1F0, 31'h00F), 0);
    send_record(random_record(1'b0), 2);
    send_record(fixed_record(0, 0, 1, 3, 2, 31'h4, 31'h3), 0);
    wait_drained();
  endtask

  // mostly well-formed records, some truncated ones and loose bytes
  task automatic test_random_records(input int n_items, input int src_pct,
                                     input int sink_pct);
    int stop_at, sel;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = bytes_sent + n_items;
    send_record(random_record(1'b1), 0);
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 6) send_byte(8'($urandom_range(255)), 1'b0);
      else if (sel < 10) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (sel < 18) send_record(random_record(1'b0), $urandom_range(4, 1));
      else if (sel < 22) send_record(random_record(1'b1), 0);
      else send_record(random_record(1'b0), 0);
    end
    wait_drained();
  endtask

  // short records back to back while the receiver holds off
  task automatic test_backpressure();
    int k;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    sink_hold_left = HOLD_OFF;
    for (k = 0; k < 24; k++) begin
      send_record(fixed_record(0, 0, 0, 0, $urandom_range(2), 31'($urandom()),
                               31'($urandom())), 0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_directed_records();
    test_restart_mid_record();
    test_random_records(470, 18, 79);
    test_random_records(470, 79, 18);
    test_backpressure();
    test_random_records(470, 0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_matrices.size() != 0) report_mismatch("matrices never delivered");
    $display("run: %0d bytes (idle, restart, truncated, widest, random) gave %0d matrices",
             bytes_sent, matrices_checked);
    $display("run: input held back %0d cycles by output back-pressure, %0d mismatches",
             stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
